// ===== sv/rmq_pkg.sv =====
// Shared constants, types and lane codes for the rotation-matrix-to-quaternion block.
package rmq_pkg;

   // Fixed-point format and element width
   localparam int FRAC_BITS  = 14;
   localparam int DATA_W     = 16;

   // Number of quaternion lanes and their codes
   localparam int LANES      = 4;
   localparam int LANE_IDX_W = 2;
   localparam logic [LANE_IDX_W-1:0] LANE_W = 2'd0;
   localparam logic [LANE_IDX_W-1:0] LANE_X = 2'd1;
   localparam logic [LANE_IDX_W-1:0] LANE_Y = 2'd2;
   localparam logic [LANE_IDX_W-1:0] LANE_Z = 2'd3;

   // Trace and root widths
   localparam int PART_W  = ((DATA_W + 2) > (FRAC_BITS + 1) ? (DATA_W + 2) : (FRAC_BITS + 1)) + 1;
   localparam int TRACE_W = PART_W + 1;
   localparam int TOTAL_W = PART_W + 2;
   localparam int ROOT_W  = FRAC_BITS + 1;
   localparam int ROOT_STEPS = ROOT_W;
   localparam int RES_W   = PART_W + 2 * FRAC_BITS + 10;
   localparam int ACC_W   = TOTAL_W + ROOT_W + 3;
   localparam int Q_W     = (ROOT_W + 1) > DATA_W ? (ROOT_W + 1) : DATA_W;

   // Front register, root steps, output register
   localparam int STAGES  = ROOT_STEPS + 2;

   typedef logic signed [DATA_W-1:0] elem_type;
   typedef logic [PART_W-1:0]        part_type;
   typedef logic [TOTAL_W-1:0]       total_type;
   typedef logic [ROOT_W-1:0]        root_type;

   typedef struct packed {
      part_type [LANES-1:0] part;
      total_type            total;
      logic [LANES-1:0]     neg;
   } front_type;

endpackage

// ===== sv/rmq_if.sv =====
// Valid/ready channel interfaces for matrix requests and quaternion responses.
interface rmq_req_if;
   logic                valid;
   logic                ready;
   rmq_pkg::elem_type   elem_r0c0;
   rmq_pkg::elem_type   elem_r0c1;
   rmq_pkg::elem_type   elem_r0c2;
   rmq_pkg::elem_type   elem_r1c0;
   rmq_pkg::elem_type   elem_r1c1;
   rmq_pkg::elem_type   elem_r1c2;
   rmq_pkg::elem_type   elem_r2c0;
   rmq_pkg::elem_type   elem_r2c1;
   rmq_pkg::elem_type   elem_r2c2;

   modport source (output valid, elem_r0c0, elem_r0c1, elem_r0c2, elem_r1c0, elem_r1c1,
                   elem_r1c2, elem_r2c0, elem_r2c1, elem_r2c2, input ready);
   modport sink   (input valid, elem_r0c0, elem_r0c1, elem_r0c2, elem_r1c0, elem_r1c1,
                   elem_r1c2, elem_r2c0, elem_r2c1, elem_r2c2, output ready);
endinterface

interface rmq_rsp_if;
   logic                valid;
   logic                ready;
   rmq_pkg::elem_type   quat_w;
   rmq_pkg::elem_type   quat_x;
   rmq_pkg::elem_type   quat_y;
   rmq_pkg::elem_type   quat_z;

   modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
   modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

// ===== sv/rotation_matrix_to_quaternion.sv =====
// Top level: front stage, four root lanes and the sign-merge output register.
//
//   channel   dir  beat                      handshake
//   req_bus   in   nine matrix elements      valid/ready
//   rsp_bus   out  quat_w/x/y/z              valid/ready
//
// One matrix per cycle sustained while rsp_bus.ready holds; the pipeline is one front
// stage, one stage per root bit in each lane, one output register.
// Every stage has its own valid bit and loads whenever its downstream slot is free,
// so bubbles close up and new beats enter while a finished result waits.
// Reset (synchronous) clears the valid bits only.
module rotation_matrix_to_quaternion (
   input  logic      clock,
   input  logic      reset,
   rmq_req_if.sink   req_bus,
   rmq_rsp_if.source rsp_bus
);
   import rmq_pkg::*;

   logic [STAGES-1:0]     valid_ff;
   logic [STAGES-1:0]     valid_in;
   logic [STAGES-1:0]     load;
   front_type             front_ff;
   logic [LANES-1:0]      neg_ff [ROOT_STEPS];
   root_type              root [LANES];
   elem_type              quat_ff [LANES];
   elem_type              quat_in [LANES];
   logic signed [Q_W-1:0] mag;

   // Load enables: a stage advances when empty or when its successor advances
   always_comb begin
      load[STAGES-1] = !valid_ff[STAGES-1] || rsp_bus.ready;
      for (int s = STAGES - 2; s >= 0; s--) begin
         load[s] = !valid_ff[s] || load[s+1];
      end
   end

   assign req_bus.ready = load[0];

   // Advance valid bits
   always_comb begin
      valid_in[0] = req_bus.valid;
      for (int s = 1; s < STAGES; s++) begin
         valid_in[s] = valid_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int s = 0; s < STAGES; s++) begin
            if (load[s]) valid_ff[s] <= valid_in[s];
         end
      end
   end

   // Front stage
   rmq_front u_front (
      .clock    (clock),
      .load     (load[0]),
      .e00      (req_bus.elem_r0c0),
      .e01      (req_bus.elem_r0c1),
      .e02      (req_bus.elem_r0c2),
      .e10      (req_bus.elem_r1c0),
      .e11      (req_bus.elem_r1c1),
      .e12      (req_bus.elem_r1c2),
      .e20      (req_bus.elem_r2c0),
      .e21      (req_bus.elem_r2c1),
      .e22      (req_bus.elem_r2c2),
      .front_ff (front_ff)
   );

   // Root lanes
   for (genvar i = 0; i < LANES; i++) begin : g_lane
      rmq_lane u_lane (
         .load  (load[ROOT_STEPS:1]),
         .clock (clock),
         .part  (front_ff.part[i]),
         .total (front_ff.total),
         .root  (root[i])
      );
   end

   // Carry sign flags alongside the lanes
   always_ff @(posedge clock) begin
      if (load[1]) neg_ff[0] <= front_ff.neg;
      for (int s = 1; s < ROOT_STEPS; s++) begin
         if (load[s+1]) neg_ff[s] <= neg_ff[s-1];
      end
   end

   // Merge: apply signs and truncate to the field width
   always_comb begin
      mag = '0;
      for (int i = 0; i < LANES; i++) begin
         mag        = $signed(Q_W'(root[i]));
         mag        = neg_ff[ROOT_STEPS-1][i] ? -mag : mag;
         quat_in[i] = mag[DATA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (load[STAGES-1]) begin
         for (int i = 0; i < LANES; i++) begin
            quat_ff[i] <= quat_in[i];
         end
      end
   end

   assign rsp_bus.valid  = valid_ff[STAGES-1];
   assign rsp_bus.quat_w = quat_ff[LANE_W];
   assign rsp_bus.quat_x = quat_ff[LANE_X];
   assign rsp_bus.quat_y = quat_ff[LANE_Y];
   assign rsp_bus.quat_z = quat_ff[LANE_Z];

   // The clamped traces always sum to at least four
   a_total_floor: assert property (@(posedge clock) disable iff (reset)
      valid_ff[0] |-> (front_ff.total >= (TOTAL_W'(4) << FRAC_BITS)))
      else $error("front total below four");

   // A beat moving into the output slot shows up there
   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[STAGES-2] && load[STAGES-1]) |=> rsp_bus.valid)
      else $error("beat lost at output stage");

   // At least one component is positive; the largest is never negated
   a_big_positive: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.quat_w > 0 || rsp_bus.quat_x > 0
                         || rsp_bus.quat_y > 0 || rsp_bus.quat_z > 0))
      else $error("no positive component");

endmodule

// ===== sv/rmq_front.sv =====
// Front stage: trace combinations, clamp, total, largest pick and sign flags.
module rmq_front (
   input  logic               clock,
   input  logic               load,
   input  rmq_pkg::elem_type  e00,
   input  rmq_pkg::elem_type  e01,
   input  rmq_pkg::elem_type  e02,
   input  rmq_pkg::elem_type  e10,
   input  rmq_pkg::elem_type  e11,
   input  rmq_pkg::elem_type  e12,
   input  rmq_pkg::elem_type  e20,
   input  rmq_pkg::elem_type  e21,
   input  rmq_pkg::elem_type  e22,
   output rmq_pkg::front_type front_ff
);
   import rmq_pkg::*;

   logic signed [TRACE_W-1:0] one;
   logic signed [TRACE_W-1:0] m00, m11, m22;
   logic signed [TRACE_W-1:0] trace [LANES];
   logic signed [DATA_W:0]    d21m12, d02m20, d10m01, s10p01, s02p20, s21p12;
   part_type [LANES-1:0]      part;
   logic [LANE_IDX_W-1:0]     big;
   logic [LANES-1:0]          neg;
   front_type                 front_in;

   // Form the four trace combinations
   always_comb begin
      one = TRACE_W'(1) <<< FRAC_BITS;
      m00 = TRACE_W'(e00);
      m11 = TRACE_W'(e11);
      m22 = TRACE_W'(e22);
      trace[LANE_W] =  m00 + m11 + m22 + one;
      trace[LANE_X] =  m00 - m11 - m22 + one;
      trace[LANE_Y] = -m00 + m11 - m22 + one;
      trace[LANE_Z] = -m00 - m11 + m22 + one;
   end

   // Clamp at zero
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         part[i] = (trace[i] > 0) ? trace[i][PART_W-1:0] : '0;
      end
   end

   // Pick the largest, ties to the lower lane
   always_comb begin
      big = LANE_W;
      if (part[LANE_X] > part[big]) big = LANE_X;
      if (part[LANE_Y] > part[big]) big = LANE_Y;
      if (part[LANE_Z] > part[big]) big = LANE_Z;
   end

   // Off-diagonal differences and sums for the signs
   always_comb begin
      d21m12 = (DATA_W+1)'(e21) - (DATA_W+1)'(e12);
      d02m20 = (DATA_W+1)'(e02) - (DATA_W+1)'(e20);
      d10m01 = (DATA_W+1)'(e10) - (DATA_W+1)'(e01);
      s10p01 = (DATA_W+1)'(e10) + (DATA_W+1)'(e01);
      s02p20 = (DATA_W+1)'(e02) + (DATA_W+1)'(e20);
      s21p12 = (DATA_W+1)'(e21) + (DATA_W+1)'(e12);
   end

   // Select sign flags by the largest lane
   always_comb begin
      neg = '0;
      case (big)
         LANE_W: begin
            neg[LANE_X] = d21m12[DATA_W];
            neg[LANE_Y] = d02m20[DATA_W];
            neg[LANE_Z] = d10m01[DATA_W];
         end
         LANE_X: begin
            neg[LANE_W] = d21m12[DATA_W];
            neg[LANE_Y] = s10p01[DATA_W];
            neg[LANE_Z] = s02p20[DATA_W];
         end
         LANE_Y: begin
            neg[LANE_W] = d02m20[DATA_W];
            neg[LANE_X] = s10p01[DATA_W];
            neg[LANE_Z] = s21p12[DATA_W];
         end
         default: begin
            neg[LANE_W] = d10m01[DATA_W];
            neg[LANE_X] = s02p20[DATA_W];
            neg[LANE_Y] = s21p12[DATA_W];
         end
      endcase
   end

   // Assemble the front beat
   always_comb begin
      front_in.part  = part;
      front_in.total = TOTAL_W'(part[LANE_W]) + TOTAL_W'(part[LANE_X])
                     + TOTAL_W'(part[LANE_Y]) + TOTAL_W'(part[LANE_Z]);
      front_in.neg   = neg;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         front_ff <= front_in;
      end
   end

endmodule

// ===== sv/rmq_lane.sv =====
// One lane: pipelined digit-by-digit root of part/total, one result bit per stage.
module rmq_lane (
   input  logic [rmq_pkg::ROOT_STEPS-1:0] load,
   input  logic                           clock,
   input  rmq_pkg::part_type              part,
   input  rmq_pkg::total_type             total,
   output rmq_pkg::root_type              root
);
   import rmq_pkg::*;

   // rem = part*2^(2F+2) - (2n-1)^2*total, acc = (2n-1)*total
   typedef struct packed {
      logic signed [RES_W-1:0] rem;
      logic signed [ACC_W-1:0] acc;
      total_type               total;
      root_type                root;
   } step_type;

   step_type step_ff [ROOT_STEPS];
   step_type step_in [ROOT_STEPS];
   step_type seed;

   // Seed with n = 0
   always_comb begin
      seed.rem   = $signed((RES_W'(part) << (2 * FRAC_BITS + 2)) - RES_W'(total));
      seed.acc   = $signed(ACC_W'(0) - ACC_W'(total));
      seed.total = total;
      seed.root  = '0;
   end

   for (genvar j = 0; j < ROOT_STEPS; j++) begin : g_step
      localparam int K = ROOT_STEPS - 1 - j;
      step_type                prev;
      logic signed [RES_W-1:0] term;

      if (j == 0) begin : g_first
         assign prev = seed;
      end else begin : g_next
         assign prev = step_ff[j-1];
      end

      // Try bit K: keep it when the square still fits
      always_comb begin
         term = (RES_W'(prev.acc) <<< (K + 2))
              + $signed(RES_W'(prev.total) << (2 * K + 2));
         step_in[j] = prev;
         if (term <= prev.rem) begin
            step_in[j].rem  = prev.rem - term;
            step_in[j].acc  = prev.acc + $signed(ACC_W'(prev.total) << (K + 1));
            step_in[j].root = prev.root | (ROOT_W'(1) << K);
         end
      end

      always_ff @(posedge clock) begin
         if (load[j]) begin
            step_ff[j] <= step_in[j];
         end
      end
   end

   assign root = step_ff[ROOT_STEPS-1].root;

endmodule
